>>> hdl/cdq_pkg.sv
// cdq_pkg: shared constants, request and status codes and the memory
// request struct of the circular deque
// no dependencies
package cdq_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // one access to the entry store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

endpackage

>>> hdl/cdq_ram.sv
// cdq_ram: single-port synchronous ram, one access per cycle,
// registered read data
// no dependencies
module cdq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/cdq_ctrl.sv
// cdq_ctrl: front and rear pointers, occupancy count, store access
// and result status of the circular deque
// depends on cdq_pkg
module cdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         operation,
  output cdq_pkg::mem_req_t  mem_req,
  output logic               done,
  output logic [1:0]         status,
  output logic               pop_ok
);

  logic [cdq_pkg::ADDR_W-1:0] front_index, front_index_next;
  logic [cdq_pkg::ADDR_W-1:0] rear_index, rear_index_next;
  logic [cdq_pkg::CNT_W-1:0]  occupancy, occupancy_next;
  logic [1:0]                 status_next;
  logic                       pop_ok_next;
  logic [cdq_pkg::ADDR_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic                       is_empty, is_full, is_single;

  localparam logic [cdq_pkg::ADDR_W-1:0] LAST_IDX = cdq_pkg::ADDR_W'(cdq_pkg::DEPTH - 1);

  // wrapping pointer steps
  assign front_inc = (front_index == LAST_IDX) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
  assign rear_inc  = (rear_index == LAST_IDX) ? '0 : rear_index + 1'b1;
  assign rear_dec  = (rear_index == '0) ? LAST_IDX : rear_index - 1'b1;

  assign is_empty  = (occupancy == '0);
  assign is_single = (occupancy == cdq_pkg::CNT_W'(1));
  assign is_full   = (occupancy == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));

  // request decode: next pointers, count, store access and status
  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    occupancy_next   = occupancy;
    status_next      = cdq_pkg::ST_OK;
    pop_ok_next      = 1'b0;
    mem_req          = '0;
    case (cdq_pkg::op_t'(operation))
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
        if (is_full) begin
          status_next = cdq_pkg::ST_OVERFLOW;
        end else if (is_empty) begin
          front_index_next = '0;
          rear_index_next  = '0;
          occupancy_next   = cdq_pkg::CNT_W'(1);
          mem_req.wr_en    = accept;
          mem_req.addr     = '0;
        end else if (cdq_pkg::op_t'(operation) == cdq_pkg::OP_PUSH_FRONT) begin
          front_index_next = front_dec;
          occupancy_next   = occupancy + 1'b1;
          mem_req.wr_en    = accept;
          mem_req.addr     = front_dec;
        end else begin
          rear_index_next  = rear_inc;
          occupancy_next   = occupancy + 1'b1;
          mem_req.wr_en    = accept;
          mem_req.addr     = rear_inc;
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
        if (is_empty) begin
          status_next = cdq_pkg::ST_UNDERFLOW;
        end else if (is_single) begin
          front_index_next = '0;
          rear_index_next  = '0;
          occupancy_next   = '0;
          pop_ok_next      = 1'b1;
          mem_req.rd_en    = accept;
          mem_req.addr     = front_index;
        end else if (cdq_pkg::op_t'(operation) == cdq_pkg::OP_POP_FRONT) begin
          front_index_next = front_inc;
          occupancy_next   = occupancy - 1'b1;
          pop_ok_next      = 1'b1;
          mem_req.rd_en    = accept;
          mem_req.addr     = front_index;
        end else begin
          rear_index_next  = rear_dec;
          occupancy_next   = occupancy - 1'b1;
          pop_ok_next      = 1'b1;
          mem_req.rd_en    = accept;
          mem_req.addr     = rear_index;
        end
      end
      default: begin
        status_next = cdq_pkg::ST_OK;
      end
    endcase
  end

  // pointer and count registers, updated on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      occupancy   <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      occupancy   <= occupancy_next;
    end
  end

  // result strobe and status, in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      pop_ok <= 1'b0;
    end else begin
      done   <= accept;
      pop_ok <= accept & pop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

endmodule

>>> hdl/circular_deque_top.sv
// circular_deque_top: double-ended queue of 32-bit values in a circular store
// depends on cdq_pkg, cdq_ctrl, cdq_ram
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------
//  request  | start / busy       | operation, data_in
//  result   | done (one cycle)   | data_out, status
//
// a request is taken on any edge with start high; busy is always low
// each request gives one result with done high in the following cycle
// the store is a single-port ram: a push writes and a pop reads at the
// request edge, pop data comes from the ram's registered read port
// one request per cycle; synchronous reset empties the queue
// the receiver cannot stall, so a result is never held back
module circular_deque_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [31:0] data_in,
  output logic               done,
  output logic signed [31:0] data_out,
  output logic [1:0]         status
);

  cdq_pkg::mem_req_t           mem_req;
  logic [cdq_pkg::DATA_W-1:0]  rdata;
  logic                        pop_ok;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // pointers, count and store access
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .mem_req   (mem_req),
    .done      (done),
    .status    (status),
    .pop_ok    (pop_ok)
  );

  // entry store
  cdq_ram #(
    .DATA_W (cdq_pkg::DATA_W),
    .DEPTH  (cdq_pkg::DEPTH),
    .ADDR_W (cdq_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .wr_en (mem_req.wr_en),
    .rd_en (mem_req.rd_en),
    .addr  (mem_req.addr),
    .wdata (data_in),
    .rdata (rdata)
  );

  // popped value, zero for pushes and underflow
  assign data_out = pop_ok ? $signed(rdata) : '0;

endmodule
